[sv/assert_macros.svh]
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define SFSD_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfsd assertion failed");

// Next-cycle implication, disabled while rst is high.
`define SFSD_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfsd assertion failed");

// Next-cycle implication that also holds across reset.
`define SFSD_ASSERT_ALWAYS_NXT(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sfsd assertion failed");

`endif

[sv/sfsd_pkg.sv]
// Package: constants, register codes and shared types of the SBUS stick decoder.
package sfsd_pkg;

  localparam int FRAME_BYTES     = 25;
  localparam int BYTE_W          = 8;
  localparam int FRAME_W         = FRAME_BYTES * BYTE_W;
  localparam int CH_W            = 11;
  localparam int OFFSET_W        = 4;
  localparam int CFG_W           = 11;
  localparam int CFG_ADDR_W      = 2;
  localparam int COUNT_W         = 5;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int OUT_TDATA_W     = 72;

  // Bit positions of the channels in the stream that starts at the offset byte.
  localparam int CH0_LSB = 0 * CH_W;
  localparam int CH1_LSB = 1 * CH_W;
  localparam int CH2_LSB = 2 * CH_W;
  localparam int CH3_LSB = 3 * CH_W;
  localparam int CH5_LSB = 5 * CH_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 5'd31;
  localparam logic [COUNT_W-1:0] FRAME_LAST = 5'(FRAME_BYTES - 1);

  localparam logic [OFFSET_W-1:0] OFFSET_RST   = 4'd2;
  localparam logic [CH_W-1:0]     ARM_RST      = 11'd1800;
  localparam logic [CH_W-1:0]     THR_FLOOR_RST = 11'd300;
  localparam logic [CH_W-1:0]     THR_CEIL_RST = 11'd2000;

  localparam logic [CH_W-1:0] THR_LOW = 11'd200;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CHANNEL_OFFSET   = 2'd0,
    REG_ARM_THRESHOLD    = 2'd1,
    REG_THROTTLE_FLOOR   = 2'd2,
    REG_THROTTLE_CEILING = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] channel_offset;
    logic [CH_W-1:0]     arm_threshold;
    logic [CH_W-1:0]     throttle_floor;
    logic [CH_W-1:0]     throttle_ceiling;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[sv/sfsd_front.sv]
// Front end: byte intake, burst length check, frame assembly.
module sfsd_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,    // [7:0] rx_byte
  input  logic                       s_tlast,
  input  sfsd_pkg::q_status_t        q_status,
  output logic                       push,
  output logic [sfsd_pkg::FRAME_W-1:0] push_data
);
  import sfsd_pkg::*;

  localparam int HIST = FRAME_BYTES - 1;

  logic [BYTE_W-1:0]  hist [HIST];
  logic [COUNT_W-1:0] burst_count;
  logic [COUNT_W-1:0] burst_count_next;
  logic               accept;

  assign s_tready = !q_status.full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && s_tlast && (burst_count == FRAME_LAST);

  always_comb begin
    burst_count_next = burst_count;
    if (accept) begin
      if (s_tlast) begin
        burst_count_next = '0;
      end else if (burst_count != COUNT_MAX) begin
        burst_count_next = burst_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_count <= '0;
    end else begin
      burst_count <= burst_count_next;
    end
  end

  // Shift line of the last bytes; oldest at index 0 once a full frame is in.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < HIST - 1; k++) begin
        hist[k] <= hist[k + 1];
      end
      hist[HIST - 1] <= s_tdata;
    end
  end

  always_comb begin
    for (int k = 0; k < HIST; k++) begin
      push_data[k*BYTE_W +: BYTE_W] = hist[k];
    end
    push_data[HIST*BYTE_W +: BYTE_W] = s_tdata;
  end

endmodule

[sv/sfsd_queue.sv]
// Frame queue between the front end and the decode pipeline.
module sfsd_queue #(
  parameter int QUEUE_DEPTH = sfsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [sfsd_pkg::FRAME_W-1:0] push_data,
  input  logic                         pop,
  output logic [sfsd_pkg::FRAME_W-1:0] pop_data,
  output sfsd_pkg::q_status_t          status
);
  import sfsd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [FRAME_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (fill == CNT_FULL);
  assign status.empty = (fill == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[sv/sfsd_back.sv]
// Back end: channel unpack, clamps and compare, then scaling into the output register.
module sfsd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  sfsd_pkg::cfg_t               cfg,
  input  sfsd_pkg::q_status_t          q_status,
  input  logic [sfsd_pkg::FRAME_W-1:0] q_data,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [sfsd_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import sfsd_pkg::*;

  // Stage A: unpacked channels
  logic               a_valid;
  logic [CH_W-1:0]    a_ch0;
  logic [CH_W-1:0]    a_ch1;
  logic [CH_W-1:0]    a_ch3;
  logic [CH_W-1:0]    a_thr;
  logic               a_armed;

  logic               out_ready;
  logic               load_a;
  logic [FRAME_W-1:0] stream;
  logic [CH_W-1:0]    ch2;
  logic [CH_W-1:0]    ch5;
  logic [CH_W-1:0]    thr_floored;
  logic [CH_W-1:0]    thr_clamped;

  logic signed [15:0] roll_d;
  logic signed [15:0] roll_v;
  logic signed [15:0] pitch_d;
  logic signed [15:0] pitch_v;
  logic signed [18:0] yaw_d;
  logic signed [18:0] yaw_v;
  logic signed [16:0] thr_d;
  logic signed [16:0] thr_v;
  logic [14:0]        roll_o;
  logic [14:0]        pitch_o;
  logic [17:0]        yaw_o;
  logic [15:0]        thr_o;

  assign out_ready = !m_tvalid || m_tready;
  assign load_a    = !a_valid || out_ready;
  assign pop       = load_a && !q_status.empty;

  // Bytes past the frame shift in as zero.
  assign stream = q_data >> {cfg.channel_offset, 3'b000};
  assign ch2    = stream[CH2_LSB +: CH_W];
  assign ch5    = stream[CH5_LSB +: CH_W];

  assign thr_floored = (ch2 < cfg.throttle_floor) ? THR_LOW : ch2;
  assign thr_clamped = (thr_floored > cfg.throttle_ceiling) ? cfg.throttle_ceiling
                                                             : thr_floored;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (load_a) begin
      a_valid <= !q_status.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_ch0   <= stream[CH0_LSB +: CH_W];
      a_ch1   <= stream[CH1_LSB +: CH_W];
      a_ch3   <= stream[CH3_LSB +: CH_W];
      a_thr   <= thr_clamped;
      a_armed <= (ch5 > cfg.arm_threshold);
    end
  end

  // Stage B: center, scale, deadband, saturate
  always_comb begin
    roll_d  = $signed({5'b0, a_ch3}) - 16'sd1024;
    roll_v  = roll_d * 16'sd15;
    if (roll_v < 16'sd1024 && roll_v > -16'sd1024) begin
      roll_v = '0;
    end
    pitch_d = $signed({5'b0, a_ch1}) - 16'sd1024;
    pitch_v = pitch_d * 16'sd15;
    if (pitch_v < 16'sd1024 && pitch_v > -16'sd1024) begin
      pitch_v = '0;
    end
    yaw_d = $signed({8'b0, a_ch0}) - 19'sd1024;
    yaw_v = yaw_d * 19'sd90;
    if (yaw_v < 19'sd2048 && yaw_v > -19'sd2048) begin
      yaw_v = '0;
    end
    thr_d = $signed({6'b0, a_thr}) - 17'sd200;
    thr_v = thr_d * 17'sd30;
    if (thr_v < 17'sd0) begin
      thr_v = '0;
    end else if (thr_v > 17'sd54000) begin
      thr_v = 17'sd54000;
    end
    roll_o  = roll_v[14:0];
    pitch_o = pitch_v[14:0];
    yaw_o   = yaw_v[17:0];
    thr_o   = thr_v[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && a_valid) begin
      m_tdata <= {7'b0, a_armed, thr_o, yaw_o, pitch_o, roll_o};
    end
  end

endmodule

[sv/sbus_frame_stick_decoder_core.sv]
// Top level of the SBUS frame stick decoder: config registers and block wiring.
//
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      tdata[7:0] rx_byte, tlast burst_end
//  m_*       out  tvalid/tready      tdata roll, pitch, yaw, throttle, armed
//  cfg_*     in   cfg_we             cfg_addr register index, cfg_data value
//
// One byte is taken per cycle; s_tready drops only while the frame queue is full.
// m_tvalid for a frame rises once the edge that takes its last byte has written the queue
// and the frame has been loaded into the unpack stage and then into the output register.
// The decode pipeline stalls from m_tready back to the queue; the intake stays open
// until the queue holds QUEUE_DEPTH frames. rst is synchronous and clears the
// burst count, the queue and all valid flags, and reloads the config defaults.
module sbus_frame_stick_decoder_core #(
  parameter int QUEUE_DEPTH = sfsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
  input  logic                              s_tlast,   // burst_end
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [14:0] roll_angle, [29:15] pitch_angle, [47:30] yaw_rate,
  // [63:48] throttle, [64] armed, [71:65] zero
  output logic [sfsd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                              cfg_we,
  input  logic [sfsd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [sfsd_pkg::CFG_W-1:0]        cfg_data
);
  import sfsd_pkg::*;

  cfg_t               cfg;
  q_status_t          q_status;
  logic               push;
  logic [FRAME_W-1:0] push_data;
  logic               pop;
  logic [FRAME_W-1:0] q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_offset   <= OFFSET_RST;
      cfg.arm_threshold    <= ARM_RST;
      cfg.throttle_floor   <= THR_FLOOR_RST;
      cfg.throttle_ceiling <= THR_CEIL_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_CHANNEL_OFFSET:   cfg.channel_offset   <= cfg_data[OFFSET_W-1:0];
        REG_ARM_THRESHOLD:    cfg.arm_threshold    <= cfg_data;
        REG_THROTTLE_FLOOR:   cfg.throttle_floor   <= cfg_data;
        REG_THROTTLE_CEILING: cfg.throttle_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  sfsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  sfsd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .status    (q_status)
  );

  sfsd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_status (q_status),
    .q_data   (q_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[sv/sfsd_checker.sv]
// Port-level checker for the SBUS stick decoder, bound to the top level.
`include "assert_macros.svh"

module sfsd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [sfsd_pkg::OUT_TDATA_W-1:0] m_tdata
);

  `SFSD_ASSERT_NXT(a_valid_holds, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `SFSD_ASSERT_NXT(a_data_holds, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
  `SFSD_ASSERT_NOW(a_pad_zero, clk, rst, m_tvalid, m_tdata[71:65] == 7'b0)
  `SFSD_ASSERT_NOW(a_thr_range, clk, rst, m_tvalid, m_tdata[63:48] <= 16'd54000)
  `SFSD_ASSERT_ALWAYS_NXT(a_reset_idle, clk, rst, !m_tvalid)

endmodule

bind sbus_frame_stick_decoder_core sfsd_checker u_sfsd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/tb_sbus_frame_stick_decoder_core.sv]
// Self-checking testbench for the SBUS frame stick decoder core.
`timescale 1ns / 100ps

module tb_sbus_frame_stick_decoder_core;
  import sfsd_pkg::*;

  localparam int CENTER       = 1024;
  localparam int TILT_GAIN    = 15;
  localparam int YAW_GAIN     = 90;
  localparam int TILT_DEAD    = 1024;
  localparam int YAW_DEAD     = 2048;
  localparam int THR_GAIN     = 30;
  localparam int THR_MAX      = 54000;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASE_ITEMS  = 160;
  localparam int HOLD_CYCLES  = 400;
  localparam int NUM_PHASES   = 8;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [7:0]             s_tdata;   // [7:0] rx_byte
  logic                   s_tlast;   // burst_end
  logic                   m_tvalid;
  logic                   m_tready;
  // [14:0] roll_angle, [29:15] pitch_angle, [47:30] yaw_rate,
  // [63:48] throttle, [64] armed, [71:65] zero
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_W-1:0]       cfg_data;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_left    = 0;
  int items_sent   = 0;
  int settings     = 1;
  int quiet_cycles = 0;

  class stick_result_board;
    logic [OFFSET_W-1:0]    offset;
    logic [CH_W-1:0]        arm_thr;
    logic [CH_W-1:0]        thr_floor;
    logic [CH_W-1:0]        thr_ceil;
    logic [7:0]             frame_buf [FRAME_BYTES];
    int unsigned            burst_len;
    logic [OUT_TDATA_W-1:0] pending_q [$];
    int unsigned            errors;
    int unsigned            frames;
    int unsigned            rejects;

    function new();
      offset    = OFFSET_RST;
      arm_thr   = ARM_RST;
      thr_floor = THR_FLOOR_RST;
      thr_ceil  = THR_CEIL_RST;
      burst_len = 0;
      errors    = 0;
      frames    = 0;
      rejects   = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_CHANNEL_OFFSET:   offset    = val[OFFSET_W-1:0];
        REG_ARM_THRESHOLD:    arm_thr   = val[CH_W-1:0];
        REG_THROTTLE_FLOOR:   thr_floor = val[CH_W-1:0];
        REG_THROTTLE_CEILING: thr_ceil  = val[CH_W-1:0];
        default: ;
      endcase
    endfunction

    // bits past the end of the frame read as zero
    function logic [CH_W-1:0] channel(int unsigned ch);
      int unsigned pos;
      logic [CH_W-1:0] v;
      for (int k = 0; k < CH_W; k++) begin
        pos = int'(offset) * 8 + ch * CH_W + k;
        v[k] = (pos < FRAME_W) ? frame_buf[pos / 8][pos % 8] : 1'b0;
      end
      return v;
    endfunction

    function int stick(logic [CH_W-1:0] ch, int gain, int dead);
      int v;
      v = (int'(ch) - CENTER) * gain;
      if (v < dead && v > -dead) v = 0;
      return v;
    endfunction

    function logic [OUT_TDATA_W-1:0] decode_sticks();
      int   roll;
      int   pitch;
      int   yaw;
      int   c2;
      int   thr;
      logic armed;
      roll  = stick(channel(3), TILT_GAIN, TILT_DEAD);
      pitch = stick(channel(1), TILT_GAIN, TILT_DEAD);
      yaw   = stick(channel(0), YAW_GAIN, YAW_DEAD);
      c2 = int'(channel(2));
      if (c2 < int'(thr_floor)) c2 = int'(THR_LOW);
      if (c2 > int'(thr_ceil)) c2 = int'(thr_ceil);
      thr = (c2 - int'(THR_LOW)) * THR_GAIN;
      if (thr < 0) thr = 0;
      if (thr > THR_MAX) thr = THR_MAX;
      armed = channel(5) > arm_thr;
      return {7'd0, armed, 16'(thr), 18'(yaw), 15'(pitch), 15'(roll)};
    endfunction

    function void note_rx_byte(logic [7:0] b, logic last);
      int unsigned count;
      if (burst_len < FRAME_BYTES) frame_buf[burst_len] = b;
      count = (burst_len < COUNT_MAX) ? burst_len + 1 : COUNT_MAX;
      if (!last) begin
        burst_len = count;
      end else begin
        burst_len = 0;
        if (count == FRAME_BYTES) pending_q.push_back(decode_sticks());
        else rejects++;
      end
    endfunction

    function string fields(logic [OUT_TDATA_W-1:0] w);
      return $sformatf("roll %0d pitch %0d yaw %0d throttle %0d armed %0d pad %h",
                       $signed(w[14:0]), $signed(w[29:15]), $signed(w[47:30]),
                       w[63:48], w[64], w[71:65]);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] got);
      logic [OUT_TDATA_W-1:0] want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: %s", $time, fields(got));
        return;
      end
      want = pending_q.pop_front();
      frames++;
      if (got !== want) begin
        errors++;
        $display("%0t: result mismatch, expected %s", $time, fields(want));
        $display("%0t: result mismatch, actual   %s", $time, fields(got));
      end
    endfunction
  endclass

  stick_result_board sb = new();

  sbus_frame_stick_decoder_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    sb.note_rx_byte(b, last);
    items_sent++;
  endtask

  // channels 4, 6 and 7 and the bytes outside the channel stream are random
  task automatic send_sticks(input logic [CH_W-1:0] yaw, pitch, thr, roll, sw);
    logic [8*CH_W-1:0] chs;
    logic [FRAME_W-1:0] bits;
    int pos;
    chs = {11'($urandom), 11'($urandom), sw, 11'($urandom), roll, thr, pitch, yaw};
    for (int i = 0; i < FRAME_BYTES; i++) bits[8*i +: 8] = 8'($urandom);
    for (int i = 0; i < 8 * CH_W; i++) begin
      pos = int'(sb.offset) * 8 + i;
      if (pos < FRAME_W) bits[pos] = chs[i];
    end
    for (int i = 0; i < FRAME_BYTES; i++) send_item(bits[8*i +: 8], i == FRAME_BYTES - 1);
  endtask

  task automatic send_junk(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(8'($urandom), i == len - 1);
  endtask

  task automatic set_config(input logic [OFFSET_W-1:0] off,
                            input logic [CH_W-1:0] arm, flo, ceil);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_CHANNEL_OFFSET;
    cfg_data <= CFG_W'(off);
    @(posedge clk);
    cfg_addr <= REG_ARM_THRESHOLD;
    cfg_data <= arm;
    @(posedge clk);
    cfg_addr <= REG_THROTTLE_FLOOR;
    cfg_data <= flo;
    @(posedge clk);
    cfg_addr <= REG_THROTTLE_CEILING;
    cfg_data <= ceil;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(REG_CHANNEL_OFFSET, CFG_W'(off));
    sb.set_reg(REG_ARM_THRESHOLD, arm);
    sb.set_reg(REG_THROTTLE_FLOOR, flo);
    sb.set_reg(REG_THROTTLE_CEILING, ceil);
  endtask

  // wait for every expected result, then keep watching to catch a stray one
  task automatic wait_drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CH_W-1:0] near(logic [CH_W-1:0] v);
    return CH_W'(int'(v) + int'($urandom_range(0, 2)) - 1);
  endfunction

  function automatic logic [CH_W-1:0] pick_ch();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      2: return CH_W'(CENTER - 80 + int'($urandom_range(0, 160)));
      3: return near(sb.arm_thr);
      4: return near(sb.thr_floor);
      5: return near(sb.thr_ceil);
      default: return CH_W'($urandom);
    endcase
  endfunction

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid === 1'b1 && m_tready) sb.check_result(m_tdata);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int p;
    int start;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_addr <= REG_CHANNEL_OFFSET;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: stick extremes, deadband edges, arm and throttle limits
    send_sticks(11'd0, 11'd0, 11'd0, 11'd0, 11'd0);
    send_sticks(11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047);
    send_sticks(11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1800);
    send_sticks(11'd1046, 11'd1092, 11'd299, 11'd956, 11'd1801);
    send_sticks(11'd1047, 11'd1093, 11'd300, 11'd955, 11'd1799);
    send_sticks(11'd1002, 11'd956, 11'd2000, 11'd1093, 11'd0);
    send_sticks(11'd1001, 11'd955, 11'd2001, 11'd1092, 11'd2047);
    // wrong lengths; 57 would alias to 25 if the count wrapped
    send_junk(24);
    send_junk(26);
    send_junk(1);
    send_junk(57);
    send_sticks(pick_ch(), pick_ch(), pick_ch(), pick_ch(), pick_ch());
    send_junk(40);
    send_sticks(pick_ch(), pick_ch(), pick_ch(), pick_ch(), pick_ch());
    s_tvalid <= 1'b0;
    wait_drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_config(OFFSET_RST, ARM_RST, THR_FLOOR_RST, THR_CEIL_RST);
        1: set_config(4'd0, 11'd0, 11'd0, 11'd2047);
        2: set_config(4'd14, 11'd2047, 11'd2047, 11'd0);
        3: set_config(4'd15, 11'($urandom), 11'd150, 11'd180);
        default: set_config(4'($urandom), 11'($urandom), 11'($urandom_range(0, 700)),
                            11'($urandom_range(1200, 2047)));
      endcase
      settings++;
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      // long receiver hold-off with a full-rate sender fills the frame queue
      if (p == 4) hold_left = HOLD_CYCLES;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85)
          send_sticks(pick_ch(), pick_ch(), pick_ch(), pick_ch(), pick_ch());
        else if ($urandom_range(0, 9) == 0)
          send_junk(60);
        else
          send_junk($urandom_range(1, 40));
      end
      s_tvalid <= 1'b0;
      wait_drain();
    end

    if (sb.pending_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending_q.size());
      sb.errors++;
    end
    $display("Sent %0d bytes under %0d register settings and four idle patterns.",
             items_sent, settings);
    $display("Checked %0d decoded frames; %0d bursts of wrong length dropped.",
             sb.frames, sb.rejects);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/sfsd_pkg.sv
sv/sfsd_front.sv
sv/sfsd_queue.sv
sv/sfsd_back.sv
sv/sbus_frame_stick_decoder_core.sv
sv/sfsd_checker.sv
tb/tb_sbus_frame_stick_decoder_core.sv
